// ===== hdl/lrfp_pkg.sv =====
`timescale 1ns / 1ps

package lrfp_pkg;

    localparam logic [7:0]  HEADER_BYTE     = 8'h59;
    localparam logic [7:0]  HEADER_SUM      = 8'hB2;
    localparam logic [2:0]  PAYLOAD_STORED  = 3'd6;

    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned CFG_DATA_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_STRENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT = 2'd2;

    localparam logic [15:0] RST_MIN_STRENGTH   = 16'd10;
    localparam logic [3:0]  RST_DISTANCE_SCALE = 4'd10;
    localparam logic [13:0] RST_DISTANCE_LIMIT = 14'd10000;

    typedef struct packed {
        logic [15:0] min_strength;
        logic [3:0]  distance_scale;
        logic [13:0] distance_limit;
    } t_cfg;

    typedef struct packed {
        logic        frame_ok;
        logic [15:0] strength;
        logic [13:0] distance;
        logic        distance_fresh;
    } t_eval;

endpackage

// ===== hdl/lrfp_if.sv =====
`timescale 1ns / 1ps

interface lrfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lrfp_result_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [15:0] strength;
    logic [13:0] distance;
    logic        distance_fresh;

    modport source (output valid, output frame_ok, output strength, output distance,
                    output distance_fresh, input ready);
    modport sink   (input valid, input frame_ok, input strength, input distance,
                    input distance_fresh, output ready);
endinterface

interface lrfp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lrfp_pkg::CFG_IDX_W-1:0]   index;
    logic [lrfp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/lrfp_frame_eval.sv =====
`timescale 1ns / 1ps

module lrfp_frame_eval (
    input  logic [7:0]            i_sum,
    input  logic [7:0]            i_checksum,
    input  logic [15:0]           i_raw_distance,
    input  logic [15:0]           i_raw_strength,
    input  lrfp_pkg::t_cfg        i_cfg,
    input  logic [15:0]           i_held_strength,
    input  logic [13:0]           i_held_distance,
    output lrfp_pkg::t_eval       o_eval
);

    logic        ok;
    logic        above_min;
    logic [19:0] scaled;
    logic [13:0] clamped;

    assign ok        = (i_sum == i_checksum);
    assign above_min = (i_raw_strength > i_cfg.min_strength);
    assign scaled    = {4'd0, i_raw_distance} * {16'd0, i_cfg.distance_scale};
    assign clamped   = (scaled > {6'd0, i_cfg.distance_limit}) ? i_cfg.distance_limit
                                                               : scaled[13:0];

    always_comb begin
        o_eval.frame_ok       = ok;
        o_eval.strength       = ok ? i_raw_strength : i_held_strength;
        o_eval.distance_fresh = ok && above_min;
        o_eval.distance       = (ok && above_min) ? clamped : i_held_distance;
    end

endmodule

// ===== hdl/lidar_range_frame_parser.sv =====
`timescale 1ns / 1ps

// Channel    Dir   Payload                                         Transaction
// i_byte     in    rx_byte[7:0]                                    valid & ready
// o_result   out   frame_ok, strength[15:0], distance[13:0], fresh valid & ready
// i_cfg      in    index[1:0], data[15:0]                          valid & ready
//
// One byte is accepted per cycle, except while the checksum byte is held off;
// a result is registered in the cycle after a frame's checksum byte is accepted.
// The checksum byte is held off only while the output register is full and stalled.
// Reset is synchronous and active low; it returns the parser to hunting the first
// header and loads the register reset values. The configuration port never stalls.

module lidar_range_frame_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lrfp_byte_if.sink      i_byte,
    lrfp_result_if.source  o_result,
    lrfp_cfg_if.sink       i_cfg
);

    typedef enum logic [1:0] {
        PH_HUNT1   = 2'd0,
        PH_HUNT2   = 2'd1,
        PH_COLLECT = 2'd2
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [2:0]      r_count, n_count;
    logic [7:0]      r_sum;
    logic [7:0]      r_dist_lo, r_dist_hi, r_str_lo, r_str_hi;
    logic [15:0]     r_held_strength;
    logic [13:0]     r_held_distance;
    lrfp_pkg::t_cfg  r_cfg;

    logic            r_out_valid;
    lrfp_pkg::t_eval r_out;

    lrfp_pkg::t_eval eval;
    logic            in_acc;
    logic            at_checksum;
    logic            result_now;

    assign at_checksum = (r_phase == PH_COLLECT) && (r_count == lrfp_pkg::PAYLOAD_STORED);
    assign i_byte.ready = !(at_checksum && r_out_valid && !o_result.ready);
    assign in_acc       = i_byte.valid && i_byte.ready;
    assign result_now   = in_acc && at_checksum;
    assign i_cfg.ready  = 1'b1;

    lrfp_frame_eval u_eval (
        .i_sum           (r_sum),
        .i_checksum      (i_byte.rx_byte),
        .i_raw_distance  ({r_dist_hi, r_dist_lo}),
        .i_raw_strength  ({r_str_hi, r_str_lo}),
        .i_cfg           (r_cfg),
        .i_held_strength (r_held_strength),
        .i_held_distance (r_held_distance),
        .o_eval          (eval)
    );

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        unique case (r_phase)
            PH_HUNT2: begin
                n_phase = (i_byte.rx_byte == lrfp_pkg::HEADER_BYTE) ? PH_COLLECT : PH_HUNT1;
                n_count = 3'd0;
            end
            PH_COLLECT: begin
                if (r_count == lrfp_pkg::PAYLOAD_STORED) begin
                    n_phase = PH_HUNT1;
                    n_count = 3'd0;
                end else begin
                    n_count = r_count + 3'd1;
                end
            end
            default: begin
                if (i_byte.rx_byte == lrfp_pkg::HEADER_BYTE) begin
                    n_phase = PH_HUNT2;
                    n_count = 3'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HUNT1;
            r_count         <= 3'd0;
            r_held_strength <= 16'd0;
            r_held_distance <= 14'd0;
            r_out_valid     <= 1'b0;
            r_cfg.min_strength   <= lrfp_pkg::RST_MIN_STRENGTH;
            r_cfg.distance_scale <= lrfp_pkg::RST_DISTANCE_SCALE;
            r_cfg.distance_limit <= lrfp_pkg::RST_DISTANCE_LIMIT;
        end else begin
            if (in_acc) begin
                r_phase <= n_phase;
                r_count <= n_count;
            end
            if (result_now) begin
                r_held_strength <= eval.strength;
                r_held_distance <= eval.distance;
                r_out_valid     <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    lrfp_pkg::REG_MIN_STRENGTH:   r_cfg.min_strength   <= i_cfg.data;
                    lrfp_pkg::REG_DISTANCE_SCALE: r_cfg.distance_scale <= i_cfg.data[3:0];
                    lrfp_pkg::REG_DISTANCE_LIMIT: r_cfg.distance_limit <= i_cfg.data[13:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (r_phase == PH_HUNT2) begin
                r_sum <= lrfp_pkg::HEADER_SUM;
            end else if (r_phase == PH_COLLECT && !at_checksum) begin
                r_sum <= r_sum + i_byte.rx_byte;
                unique case (r_count)
                    3'd0:    r_dist_lo <= i_byte.rx_byte;
                    3'd1:    r_dist_hi <= i_byte.rx_byte;
                    3'd2:    r_str_lo  <= i_byte.rx_byte;
                    3'd3:    r_str_hi  <= i_byte.rx_byte;
                    default: ;
                endcase
            end
        end
        if (result_now) begin
            r_out <= eval;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.frame_ok       = r_out.frame_ok;
    assign o_result.strength       = r_out.strength;
    assign o_result.distance       = r_out.distance;
    assign o_result.distance_fresh = r_out.distance_fresh;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lrfp_pkg::PAYLOAD_STORED)
        else $error("payload count beyond the stored payload length");

    a_fresh_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.distance_fresh |-> o_result.frame_ok)
        else $error("distance marked fresh on a frame with a bad checksum");

    a_frame_end_rehunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result_now |=> (r_phase == PH_HUNT1) && (r_count == 3'd0) && r_out_valid)
        else $error("parser did not return to header hunt after a frame");

    a_held_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.strength == r_held_strength))
        else $error("reported strength differs from the held strength");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lrfp_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT1   = 2'd0,
        PH_HUNT2   = 2'd1,
        PH_COLLECT = 2'd2
    } t_parse_phase;

    typedef struct {
        logic [7:0] rx_byte;
        bit         has_eval;
        t_eval      eval;
    } t_dir_row;

    localparam int NUM_DIR     = 29;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 120;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 4;
    localparam t_eval NO_EVAL  = '0;

    logic i_clk;
    logic i_rst_n;

    lrfp_byte_if   byte_ch ();
    lrfp_result_if res_ch ();
    lrfp_cfg_if    cfg_ch ();

    lidar_range_frame_parser DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    // Frame parser predictor state.
    t_parse_phase parse_phase;
    logic [2:0]   payload_cnt;
    logic [7:0]   payload_mem [6];
    logic [15:0]  held_strength;
    logic [13:0]  held_distance;
    t_cfg         cfg_shadow;

    t_eval awaited_frames [$];
    t_eval last_eval;
    bit    last_has_eval;

    int err_count;
    int items_sent;
    bit idle_on;
    bit hold_req;
    int hold_left;
    int stall_left;

    t_dir_row dir_tab [NUM_DIR] = '{
        '{8'h59, 1'b0, NO_EVAL}, '{8'h59, 1'b0, NO_EVAL},
        '{8'h00, 1'b0, NO_EVAL}, '{8'h00, 1'b0, NO_EVAL},
        '{8'h00, 1'b0, NO_EVAL}, '{8'h00, 1'b0, NO_EVAL},
        '{8'h00, 1'b0, NO_EVAL}, '{8'h00, 1'b0, NO_EVAL},
        '{8'h00, 1'b1, '{1'b0, 16'h0000, 14'd0, 1'b0}},
        '{8'h59, 1'b0, NO_EVAL}, '{8'h00, 1'b0, NO_EVAL},
        '{8'h59, 1'b0, NO_EVAL}, '{8'h59, 1'b0, NO_EVAL},
        '{8'hFF, 1'b0, NO_EVAL}, '{8'hFF, 1'b0, NO_EVAL},
        '{8'hFF, 1'b0, NO_EVAL}, '{8'hFF, 1'b0, NO_EVAL},
        '{8'h00, 1'b0, NO_EVAL}, '{8'h00, 1'b0, NO_EVAL},
        '{8'hAE, 1'b1, '{1'b1, 16'hFFFF, 14'd10000, 1'b1}},
        '{8'h59, 1'b0, NO_EVAL}, '{8'h59, 1'b0, NO_EVAL},
        '{8'h59, 1'b0, NO_EVAL}, '{8'h00, 1'b0, NO_EVAL},
        '{8'h0A, 1'b0, NO_EVAL}, '{8'h00, 1'b0, NO_EVAL},
        '{8'h00, 1'b0, NO_EVAL}, '{8'h00, 1'b0, NO_EVAL},
        '{8'h15, 1'b1, '{1'b1, 16'h000A, 14'd10000, 1'b0}}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit parse_rx_byte(input logic [7:0] b, output t_eval res);
        logic [7:0]  sum;
        logic [31:0] scaled;
        bit          ok;
        res = '0;
        case (parse_phase)
            PH_HUNT2: begin
                if (b == HEADER_BYTE) begin
                    parse_phase = PH_COLLECT;
                    payload_cnt = 3'd0;
                end else begin
                    parse_phase = PH_HUNT1;
                end
                return 1'b0;
            end
            PH_COLLECT: begin
                if (payload_cnt < PAYLOAD_STORED) begin
                    payload_mem[payload_cnt] = b;
                    payload_cnt = payload_cnt + 3'd1;
                    return 1'b0;
                end
                sum = HEADER_BYTE + HEADER_BYTE;
                for (int i = 0; i < 6; i++) begin
                    sum = sum + payload_mem[i];
                end
                ok = (sum == b);
                parse_phase = PH_HUNT1;
                payload_cnt = 3'd0;
                res.distance_fresh = 1'b0;
                if (ok) begin
                    held_strength = {payload_mem[3], payload_mem[2]};
                    if (held_strength > cfg_shadow.min_strength) begin
                        scaled = {16'd0, payload_mem[1], payload_mem[0]}
                                 * {28'd0, cfg_shadow.distance_scale};
                        if (scaled > {18'd0, cfg_shadow.distance_limit}) begin
                            scaled = {18'd0, cfg_shadow.distance_limit};
                        end
                        held_distance = scaled[13:0];
                        res.distance_fresh = 1'b1;
                    end
                end
                res.frame_ok = ok;
                res.strength = held_strength;
                res.distance = held_distance;
                return 1'b1;
            end
            default: begin
                if (b == HEADER_BYTE) begin
                    parse_phase = PH_HUNT2;
                    payload_cnt = 3'd0;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_field(input string tag, input string field,
                                input logic [15:0] exp_v, input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            err_count++;
            $display("%0t %s %s: expected %h, actual %h", $time, tag, field, exp_v, got_v);
        end
    endtask

    task automatic check_eval(input string tag, input t_eval exp_e, input t_eval got_e);
        report_field(tag, "frame_ok", {15'd0, exp_e.frame_ok}, {15'd0, got_e.frame_ok});
        report_field(tag, "strength", exp_e.strength, got_e.strength);
        report_field(tag, "distance", {2'd0, exp_e.distance}, {2'd0, got_e.distance});
        report_field(tag, "distance_fresh", {15'd0, exp_e.distance_fresh},
                     {15'd0, got_e.distance_fresh});
    endtask

    always @(posedge i_clk) begin : monitor
        t_eval got;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.frame_ok       = res_ch.frame_ok;
                got.strength       = res_ch.strength;
                got.distance       = res_ch.distance;
                got.distance_fresh = res_ch.distance_fresh;
                if (awaited_frames.size() == 0) begin
                    err_count++;
                    $display("%0t unexpected result: expected none, actual %h", $time, got);
                end else begin
                    check_eval("result", awaited_frames.pop_front(), got);
                end
            end
            if (byte_ch.valid && byte_ch.ready) begin
                last_has_eval = parse_rx_byte(byte_ch.rx_byte, last_eval);
                if (last_has_eval) begin
                    awaited_frames.push_back(last_eval);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_MIN_STRENGTH:   cfg_shadow.min_strength   = cfg_ch.data;
                    REG_DISTANCE_SCALE: cfg_shadow.distance_scale = cfg_ch.data[3:0];
                    REG_DISTANCE_LIMIT: cfg_shadow.distance_limit = cfg_ch.data[13:0];
                    default: ;
                endcase
            end
        end
    end

    initial begin
        res_ch.ready = 1'b0;
        hold_left    = 0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        while (awaited_frames.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic send_random_chunk();
        logic [7:0]  pay [6];
        logic [7:0]  sum;
        logic [15:0] strg;
        logic [15:0] raw_dist;
        int          kind;
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
            case ($urandom_range(0, 3))
                0: strg = 16'($urandom_range(0, 65535));
                1: strg = cfg_shadow.min_strength;
                2: strg = cfg_shadow.min_strength + 16'd1;
                default: strg = 16'($urandom_range(0, 31));
            endcase
            raw_dist = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 2000));
            pay[0] = raw_dist[7:0];
            pay[1] = raw_dist[15:8];
            pay[2] = strg[7:0];
            pay[3] = strg[15:8];
            pay[4] = 8'($urandom_range(0, 255));
            pay[5] = 8'($urandom_range(0, 255));
            sum = HEADER_BYTE + HEADER_BYTE;
            for (int i = 0; i < 6; i++) begin
                sum = sum + pay[i];
            end
            if ($urandom_range(0, 7) == 0) begin
                sum = sum ^ (8'd1 << $urandom_range(0, 7));
            end
            send_byte(HEADER_BYTE);
            send_byte(HEADER_BYTE);
            for (int i = 0; i < 6; i++) begin
                send_byte(pay[i]);
            end
            send_byte(sum);
        end else if (kind == 8) begin
            send_byte(HEADER_BYTE);
            if ($urandom_range(0, 1) == 0) begin
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(HEADER_BYTE);
                repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                send_byte(($urandom_range(0, 3) == 0) ? HEADER_BYTE
                                                      : 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        int start_cnt;
        i_rst_n         = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = 8'd0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_MIN_STRENGTH;
        cfg_ch.data     = 16'd0;
        parse_phase     = PH_HUNT1;
        payload_cnt     = 3'd0;
        held_strength   = 16'd0;
        held_distance   = 14'd0;
        cfg_shadow      = '{RST_MIN_STRENGTH, RST_DISTANCE_SCALE, RST_DISTANCE_LIMIT};
        err_count       = 0;
        items_sent      = 0;
        idle_on         = 1'b1;
        hold_req        = 1'b0;
        last_has_eval   = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_DIR; k++) begin
            send_byte(dir_tab[k].rx_byte);
            if (dir_tab[k].has_eval) begin
                if (!last_has_eval) begin
                    err_count++;
                    $display("%0t directed row %0d: expected %h, actual none",
                             $time, k, dir_tab[k].eval);
                end else begin
                    check_eval("directed", dir_tab[k].eval, last_eval);
                end
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            idle_on = (ph != NUM_PHASES - 1);
            case (ph)
                1: begin
                    write_reg(REG_MIN_STRENGTH, 16'd0);
                    write_reg(REG_DISTANCE_SCALE, 16'd15);
                    write_reg(REG_DISTANCE_LIMIT, 16'd16383);
                end
                2: begin
                    write_reg(REG_MIN_STRENGTH, 16'd65535);
                    write_reg(REG_DISTANCE_SCALE, 16'd1);
                    write_reg(REG_DISTANCE_LIMIT, 16'd0);
                end
                3: begin
                    write_reg(REG_MIN_STRENGTH, 16'd0);
                    write_reg(REG_DISTANCE_SCALE, 16'd0);
                    write_reg(REG_DISTANCE_LIMIT, 16'd16383);
                end
                6: begin
                    write_reg(REG_MIN_STRENGTH, 16'd65535);
                    write_reg(REG_DISTANCE_SCALE, 16'd15);
                    write_reg(REG_DISTANCE_LIMIT, 16'd16383);
                end
                default: begin
                    write_reg(REG_MIN_STRENGTH, 16'($urandom_range(0, 65535)));
                    write_reg(REG_DISTANCE_SCALE, 16'($urandom_range(0, 15)));
                    write_reg(REG_DISTANCE_LIMIT, 16'($urandom_range(0, 16383)));
                end
            endcase
            cfg_ch.valid <= 1'b0;
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            start_cnt = items_sent;
            while (items_sent - start_cnt < PHASE_ITEMS) begin
                send_random_chunk();
            end
        end
        drain_results();

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lrfp_pkg.sv
hdl/lrfp_if.sv
hdl/lrfp_frame_eval.sv
hdl/lidar_range_frame_parser.sv
tb/testbench.sv
